@@ rtl/kptt_pkg.sv @@
package kptt_pkg;

    localparam int POS_W   = 19;
    localparam int EST_W   = 20;
    localparam int ANG_W   = 17;
    localparam int VAR_W   = 32;
    localparam int CFGV_W  = 25;
    localparam int GAIN_W  = 16;
    localparam int TIME_W  = 32;
    localparam int TPOS_W  = 27;
    localparam int PROD_W  = 59;
    localparam int DVD_W   = 58;
    localparam int DVS_W   = 33;
    localparam int QUO_W   = 32;
    localparam int CFGI_W  = 3;

    localparam logic signed [TPOS_W-1:0] IMG_X_MAX = TPOS_W'(640 * 256);
    localparam logic signed [TPOS_W-1:0] IMG_Y_MAX = TPOS_W'(480 * 256);
    localparam logic signed [EST_W-1:0]  PIX_ONE   = EST_W'(256);

    localparam logic [1:0] CMD_DETECT = 2'd0;
    localparam logic [1:0] CMD_ANGLE  = 2'd1;
    localparam logic [1:0] CMD_FRAME  = 2'd2;

    localparam logic [1:0] KIND_PRED    = 2'd0;
    localparam logic [1:0] KIND_EST     = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    localparam logic [CFGI_W-1:0] REG_SENSOR_VAR_X = 3'd0;
    localparam logic [CFGI_W-1:0] REG_SENSOR_VAR_Y = 3'd1;
    localparam logic [CFGI_W-1:0] REG_MOTION_VAR_X = 3'd2;
    localparam logic [CFGI_W-1:0] REG_MOTION_VAR_Y = 3'd3;
    localparam logic [CFGI_W-1:0] REG_GAIN_X       = 3'd4;
    localparam logic [CFGI_W-1:0] REG_GAIN_Y       = 3'd5;
    localparam logic [CFGI_W-1:0] REG_TIMEOUT      = 3'd6;

    typedef struct packed {
        logic [CFGV_W-1:0] sensor_var_x;
        logic [CFGV_W-1:0] sensor_var_y;
        logic [CFGV_W-1:0] motion_var_x;
        logic [CFGV_W-1:0] motion_var_y;
        logic [GAIN_W-1:0] gain_x;
        logic [GAIN_W-1:0] gain_y;
        logic [7:0]        timeout_seconds;
    } cfg_t;

    typedef struct packed {
        logic [1:0]              command;
        logic signed [POS_W-1:0] det_x;
        logic signed [POS_W-1:0] det_y;
        logic signed [ANG_W-1:0] cam_yaw;
        logic signed [ANG_W-1:0] cam_pitch;
        logic [TIME_W-1:0]       now_seconds;
    } item_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [VAR_W-1:0]        var_x;
        logic [VAR_W-1:0]        var_y;
        logic                    last;
    } res_t;

endpackage

@@ rtl/pan_tilt_target_kalman_tracker.sv @@
// A detection while tracking runs up to four 32-step divisions, two per axis,
// through the one shared restoring divider.
// Throughput: one item at a time; s_tready is high only while the sequencer idles.
// Reset: asynchronous, active low; clears the filter state and loads the
// default configuration values.
module pan_tilt_target_kalman_tracker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [103:0]                 s_tdata,  // det_x, det_y, cam_yaw, cam_pitch, now_seconds
    input  logic [1:0]                   s_tuser,  // command
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [103:0]                 m_tdata,  // pos_x, pos_y, var_x, var_y, zero pad
    output logic [1:0]                   m_tuser,  // kind
    output logic                         m_tlast,
    input  logic                         cfg_we,
    input  logic [kptt_pkg::CFGI_W-1:0]  cfg_index,
    input  logic [kptt_pkg::CFGV_W-1:0]  cfg_data
);
    import kptt_pkg::*;

    cfg_t  cfg_reg;
    item_t item;
    res_t  res;
    logic  core_idle;
    logic  res_valid;
    logic  res_ready;
    logic  m_tvalid_reg;
    res_t  m_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sensor_var_x    <= CFGV_W'(454853);
            cfg_reg.sensor_var_y    <= CFGV_W'(1999032);
            cfg_reg.motion_var_x    <= CFGV_W'(30985);
            cfg_reg.motion_var_y    <= CFGV_W'(30985);
            cfg_reg.gain_x          <= GAIN_W'(4096);
            cfg_reg.gain_y          <= GAIN_W'(3072);
            cfg_reg.timeout_seconds <= 8'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SENSOR_VAR_X: cfg_reg.sensor_var_x    <= cfg_data;
                REG_SENSOR_VAR_Y: cfg_reg.sensor_var_y    <= cfg_data;
                REG_MOTION_VAR_X: cfg_reg.motion_var_x    <= cfg_data;
                REG_MOTION_VAR_Y: cfg_reg.motion_var_y    <= cfg_data;
                REG_GAIN_X:       cfg_reg.gain_x          <= cfg_data[GAIN_W-1:0];
                REG_GAIN_Y:       cfg_reg.gain_y          <= cfg_data[GAIN_W-1:0];
                REG_TIMEOUT:      cfg_reg.timeout_seconds <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        item.command     = s_tuser;
        item.det_x       = s_tdata[18:0];
        item.det_y       = s_tdata[37:19];
        item.cam_yaw     = s_tdata[54:38];
        item.cam_pitch   = s_tdata[71:55];
        item.now_seconds = s_tdata[103:72];
    end

    assign s_tready  = core_idle;
    assign res_ready = !m_tvalid_reg || m_tready;

    kptt_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_tvalid && core_idle),
        .item      (item),
        .cfg       (cfg_reg),
        .idle      (core_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            m_res_reg    <= '0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
            if (res_valid)
            begin
                m_res_reg <= res;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_res_reg.kind;
    assign m_tlast  = m_res_reg.last;
    assign m_tdata  = {2'b00, m_res_reg.var_y, m_res_reg.var_x,
                       m_res_reg.pos_y, m_res_reg.pos_x};

endmodule

@@ rtl/kptt_div.sv @@
module kptt_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [kptt_pkg::DVD_W-1:0]  dividend,
    input  logic [kptt_pkg::DVS_W-1:0]  divisor,
    output logic                        done,
    output logic [kptt_pkg::QUO_W-1:0]  quotient
);
    import kptt_pkg::*;

    // The caller guarantees the quotient fits in QUO_W bits, so the upper
    // dividend bits already start below the divisor.
    localparam logic [5:0] STEPS = 6'(QUO_W);

    logic [DVS_W:0]   rem_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           qbit;

    always_comb
    begin
        trial = {rem_reg[DVS_W-1:0], quo_reg[QUO_W-1]};
        diff  = trial - {1'b0, divisor};
        qbit  = (trial >= {1'b0, divisor});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            rem_reg  <= (DVS_W+1)'(dividend[DVD_W-1:QUO_W]);
            quo_reg  <= dividend[QUO_W-1:0];
            cnt_reg  <= STEPS;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= qbit ? diff : trial;
            quo_reg  <= {quo_reg[QUO_W-2:0], qbit};
            cnt_reg  <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/kptt_core.sv @@
module kptt_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  kptt_pkg::item_t  item,
    input  kptt_pkg::cfg_t   cfg,
    output logic             idle,
    output logic             res_valid,
    input  logic             res_ready,
    output kptt_pkg::res_t   res
);
    import kptt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_PRED, S_PMX, S_PTX, S_PTY, S_PAPPLY, S_PRST,
        S_USTART, S_UM1, S_UD1, S_UW1, S_UM2, S_UD2, S_UW2, S_UNEXT,
        S_UCHK, S_UPUSH, S_FIN
    } state_t;

    state_t state_reg;

    logic                     tracking_reg;
    logic signed [EST_W-1:0]  est_x_reg, est_y_reg, pred_x_reg, pred_y_reg;
    logic [VAR_W-1:0]         est_var_x_reg, est_var_y_reg;
    logic [VAR_W-1:0]         pred_var_x_reg, pred_var_y_reg;
    logic signed [ANG_W-1:0]  ang_rd_yaw_reg, ang_rd_pitch_reg;
    logic signed [ANG_W-1:0]  ang_used_yaw_reg, ang_used_pitch_reg;
    logic [TIME_W-1:0]        last_det_reg;

    logic [1:0]               cmd_reg;
    logic                     init_reg;
    logic                     ax_reg;
    logic signed [POS_W-1:0]  det_x_reg, det_y_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [TPOS_W-1:0] tx_reg, ty_reg;
    logic [VAR_W-1:0]         vx_reg, vy_reg;
    res_t                     pend_reg;
    logic                     pend_valid_reg;

    logic signed [ANG_W:0]    dx_yaw, dx_pitch;
    logic signed [DVS_W-1:0]  mul_a;
    logic signed [25:0]       mul_b;
    logic [PROD_W-2:0]        prod_mag;
    logic [25:0]              q8;
    logic signed [EST_W-1:0]  rnd_est;
    logic signed [TPOS_W-1:0] rnd_t;
    logic [VAR_W-1:0]         ax_p;
    logic [CFGV_W-1:0]        ax_r;
    logic signed [EST_W-1:0]  ax_pred;
    logic signed [POS_W-1:0]  ax_det;
    logic signed [20:0]       resid;
    logic [DVS_W-1:0]         s_sum;
    logic [DVD_W-1:0]         dividend;
    logic                     div_start;
    logic                     div_done;
    logic [QUO_W-1:0]         div_q;
    logic signed [TPOS_W-1:0] upd_t;
    logic [DVS_W-1:0]         sat_x, sat_y;
    logic [VAR_W-1:0]         nvar_x, nvar_y;
    logic signed [TIME_W:0]   age;
    logic                     in_img_pred, in_img_upd;

    always_comb
    begin
        dx_yaw   = (ANG_W+1)'(ang_rd_yaw_reg) - (ANG_W+1)'(ang_used_yaw_reg);
        dx_pitch = (ANG_W+1)'(ang_rd_pitch_reg) - (ANG_W+1)'(ang_used_pitch_reg);

        ax_p    = ax_reg ? pred_var_y_reg : pred_var_x_reg;
        ax_r    = ax_reg ? cfg.sensor_var_y : cfg.sensor_var_x;
        ax_pred = ax_reg ? pred_y_reg : pred_x_reg;
        ax_det  = ax_reg ? det_y_reg : det_x_reg;
        resid   = 21'(ax_det) - 21'(ax_pred);
        s_sum   = {1'b0, ax_p} + DVS_W'(ax_r);

        case (state_reg)
            S_PMX:
            begin
                mul_a = DVS_W'(cfg.gain_x);
                mul_b = 26'(dx_yaw);
            end
            S_PTX:
            begin
                mul_a = DVS_W'(cfg.gain_y);
                mul_b = 26'(dx_pitch);
            end
            S_UM1:
            begin
                mul_a = {1'b0, ax_p};
                mul_b = 26'(resid);
            end
            default:
            begin
                mul_a = {1'b0, ax_p};
                mul_b = 26'(ax_r);
            end
        endcase

        prod_mag = prod_reg[PROD_W-1] ? (PROD_W-1)'(-prod_reg)
                                      : prod_reg[PROD_W-2:0];
        dividend = DVD_W'(prod_mag) + DVD_W'(s_sum[DVS_W-1:1]);

        // Rounded gain times angle step, ties away from zero.
        q8      = 26'((35'(prod_mag[33:0]) + 35'd128) >> 8);
        rnd_est = (state_reg == S_PTY) ? est_y_reg : est_x_reg;
        rnd_t   = prod_reg[PROD_W-1] ? TPOS_W'(rnd_est) - TPOS_W'(q8)
                                     : TPOS_W'(rnd_est) + TPOS_W'(q8);

        upd_t = prod_reg[PROD_W-1] ? TPOS_W'(ax_pred) - TPOS_W'(div_q[25:0])
                                   : TPOS_W'(ax_pred) + TPOS_W'(div_q[25:0]);

        sat_x  = {1'b0, est_var_x_reg} + DVS_W'(cfg.motion_var_x);
        sat_y  = {1'b0, est_var_y_reg} + DVS_W'(cfg.motion_var_y);
        nvar_x = sat_x[DVS_W-1] ? '1 : sat_x[VAR_W-1:0];
        nvar_y = sat_y[DVS_W-1] ? '1 : sat_y[VAR_W-1:0];

        // Signed age, so time running backwards never times out.
        age = $signed({1'b0, item.now_seconds}) - $signed({1'b0, last_det_reg});

        in_img_pred = (tx_reg >= 0) && (tx_reg <= IMG_X_MAX)
                   && (ty_reg >= 0) && (ty_reg <= IMG_Y_MAX);
        in_img_upd  = in_img_pred;

        div_start = (state_reg == S_UD1) || (state_reg == S_UD2);
    end

    kptt_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (s_sum),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        res       = pend_reg;
        res.last  = (state_reg == S_FIN);
        res_valid = pend_valid_reg && ((state_reg == S_FIN) || (state_reg == S_UPUSH));
    end

    assign idle = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            tracking_reg       <= 1'b0;
            est_x_reg          <= '0;
            est_y_reg          <= '0;
            pred_x_reg         <= '0;
            pred_y_reg         <= '0;
            est_var_x_reg      <= '0;
            est_var_y_reg      <= '0;
            pred_var_x_reg     <= '0;
            pred_var_y_reg     <= '0;
            ang_rd_yaw_reg     <= '0;
            ang_rd_pitch_reg   <= '0;
            ang_used_yaw_reg   <= '0;
            ang_used_pitch_reg <= '0;
            last_det_reg       <= '0;
            cmd_reg            <= CMD_DETECT;
            init_reg           <= 1'b0;
            ax_reg             <= 1'b0;
            det_x_reg          <= '0;
            det_y_reg          <= '0;
            prod_reg           <= '0;
            tx_reg             <= '0;
            ty_reg             <= '0;
            vx_reg             <= '0;
            vy_reg             <= '0;
            pend_reg           <= '0;
            pend_valid_reg     <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= item.command;
                        det_x_reg <= item.det_x;
                        det_y_reg <= item.det_y;
                        case (item.command)
                            CMD_DETECT:
                            begin
                                last_det_reg <= item.now_seconds;
                                init_reg     <= !tracking_reg;
                                if (!tracking_reg)
                                begin
                                    est_x_reg    <= EST_W'(item.det_x);
                                    est_y_reg    <= EST_W'(item.det_y);
                                    tracking_reg <= 1'b1;
                                end
                                state_reg <= S_PRED;
                            end
                            CMD_ANGLE:
                            begin
                                ang_rd_yaw_reg   <= item.cam_yaw;
                                ang_rd_pitch_reg <= item.cam_pitch;
                                state_reg        <= S_PRED;
                            end
                            CMD_FRAME:
                            begin
                                if (age > $signed((TIME_W+1)'(cfg.timeout_seconds)))
                                begin
                                    tracking_reg   <= 1'b0;
                                    pred_x_reg     <= '0;
                                    pred_y_reg     <= '0;
                                    pred_var_x_reg <= '0;
                                    pred_var_y_reg <= '0;
                                    est_var_x_reg  <= '0;
                                    est_var_y_reg  <= '0;
                                    pend_reg       <= '{kind: KIND_TIMEOUT, pos_x: '0,
                                                        pos_y: '0, var_x: '0,
                                                        var_y: '0, last: 1'b0};
                                    pend_valid_reg <= 1'b1;
                                end
                                state_reg <= S_FIN;
                            end
                            default:
                            begin
                                state_reg <= S_FIN;
                            end
                        endcase
                    end
                end
                S_PRED:
                begin
                    state_reg <= tracking_reg ? S_PMX : S_FIN;
                end
                S_PMX:
                begin
                    prod_reg  <= PROD_W'(mul_a * mul_b);
                    state_reg <= S_PTX;
                end
                S_PTX:
                begin
                    tx_reg    <= rnd_t;
                    prod_reg  <= PROD_W'(mul_a * mul_b);
                    state_reg <= S_PTY;
                end
                S_PTY:
                begin
                    ty_reg    <= rnd_t;
                    state_reg <= S_PAPPLY;
                end
                S_PAPPLY:
                begin
                    ang_used_yaw_reg   <= ang_rd_yaw_reg;
                    ang_used_pitch_reg <= ang_rd_pitch_reg;
                    if (in_img_pred)
                    begin
                        est_x_reg      <= EST_W'(tx_reg);
                        est_y_reg      <= EST_W'(ty_reg);
                        pred_x_reg     <= EST_W'(tx_reg);
                        pred_y_reg     <= EST_W'(ty_reg);
                        est_var_x_reg  <= nvar_x;
                        est_var_y_reg  <= nvar_y;
                        pred_var_x_reg <= nvar_x;
                        pred_var_y_reg <= nvar_y;
                        pend_reg.kind  <= KIND_PRED;
                        pend_reg.pos_x <= POS_W'(tx_reg);
                        pend_reg.pos_y <= POS_W'(ty_reg);
                        pend_reg.var_x <= nvar_x;
                        pend_reg.var_y <= nvar_y;
                        pend_reg.last  <= 1'b0;
                        pend_valid_reg <= 1'b1;
                    end
                    state_reg <= S_PRST;
                end
                S_PRST:
                begin
                    // The check looks at the stored prediction, even a stale one.
                    if ((pred_x_reg < PIX_ONE) && (pred_y_reg < PIX_ONE))
                    begin
                        tracking_reg   <= 1'b0;
                        pred_x_reg     <= '0;
                        pred_y_reg     <= '0;
                        pred_var_x_reg <= '0;
                        pred_var_y_reg <= '0;
                        est_var_x_reg  <= '0;
                        est_var_y_reg  <= '0;
                    end
                    ax_reg    <= 1'b0;
                    state_reg <= ((cmd_reg == CMD_DETECT) && !init_reg) ? S_USTART : S_FIN;
                end
                S_USTART:
                begin
                    if (s_sum == '0)
                    begin
                        if (ax_reg)
                        begin
                            ty_reg <= TPOS_W'(ax_pred);
                            vy_reg <= '0;
                        end
                        else
                        begin
                            tx_reg <= TPOS_W'(ax_pred);
                            vx_reg <= '0;
                        end
                        state_reg <= S_UNEXT;
                    end
                    else
                    begin
                        state_reg <= S_UM1;
                    end
                end
                S_UM1:
                begin
                    prod_reg  <= PROD_W'(mul_a * mul_b);
                    state_reg <= S_UD1;
                end
                S_UD1:
                begin
                    state_reg <= S_UW1;
                end
                S_UW1:
                begin
                    if (div_done)
                    begin
                        if (ax_reg)
                        begin
                            ty_reg <= upd_t;
                        end
                        else
                        begin
                            tx_reg <= upd_t;
                        end
                        state_reg <= S_UM2;
                    end
                end
                S_UM2:
                begin
                    prod_reg  <= PROD_W'(mul_a * mul_b);
                    state_reg <= S_UD2;
                end
                S_UD2:
                begin
                    state_reg <= S_UW2;
                end
                S_UW2:
                begin
                    if (div_done)
                    begin
                        if (ax_reg)
                        begin
                            vy_reg <= div_q;
                        end
                        else
                        begin
                            vx_reg <= div_q;
                        end
                        state_reg <= S_UNEXT;
                    end
                end
                S_UNEXT:
                begin
                    ax_reg    <= 1'b1;
                    state_reg <= ax_reg ? S_UCHK : S_USTART;
                end
                S_UCHK:
                begin
                    if (in_img_upd)
                    begin
                        est_x_reg     <= EST_W'(tx_reg);
                        est_y_reg     <= EST_W'(ty_reg);
                        est_var_x_reg <= vx_reg;
                        est_var_y_reg <= vy_reg;
                        if (pend_valid_reg)
                        begin
                            state_reg <= S_UPUSH;
                        end
                        else
                        begin
                            pend_reg.kind  <= KIND_EST;
                            pend_reg.pos_x <= POS_W'(tx_reg);
                            pend_reg.pos_y <= POS_W'(ty_reg);
                            pend_reg.var_x <= vx_reg;
                            pend_reg.var_y <= vy_reg;
                            pend_valid_reg <= 1'b1;
                            state_reg      <= S_FIN;
                        end
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_UPUSH:
                begin
                    // The prediction beat goes out first, then the estimate waits.
                    if (res_ready)
                    begin
                        pend_reg.kind  <= KIND_EST;
                        pend_reg.pos_x <= POS_W'(est_x_reg);
                        pend_reg.pos_y <= POS_W'(est_y_reg);
                        pend_reg.var_x <= est_var_x_reg;
                        pend_reg.var_y <= est_var_y_reg;
                        state_reg      <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (res_ready)
                    begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ tb/sv/pan_tilt_target_kalman_tracker_tb.sv @@
`timescale 1ns / 1ps

module pan_tilt_target_kalman_tracker_tb;
    import kptt_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;   // det_x, det_y, cam_yaw, cam_pitch, now_seconds
    logic [1:0]   s_tuser;   // command
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;   // pos_x, pos_y, var_x, var_y, zero pad
    logic [1:0]   m_tuser;   // kind
    logic         m_tlast;
    logic         cfg_we;
    logic [CFGI_W-1:0] cfg_index;
    logic [CFGV_W-1:0] cfg_data;

    pan_tilt_target_kalman_tracker u_dut (.*);

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam longint IMG_W_Q = 640 * 256;
    localparam longint IMG_H_Q = 480 * 256;
    localparam longint VAR_MAX = 64'hFFFF_FFFF;

    typedef struct {
        logic [1:0] cmd;
        longint     dx, dy, yaw, pitch, now;
        bit         typed;
        res_t       want;
    } row_t;

    // Tracker copy kept by the testbench.
    longint sens_x, sens_y, mot_x, mot_y, gn_x, gn_y, tmo;
    bit     trk;
    longint est_x, est_y, prd_x, prd_y, evar_x, evar_y, pvar_x, pvar_y;
    longint ang_rd_y, ang_rd_p, ang_us_y, ang_us_p, last_det;

    res_t   track_q[$];
    row_t   dir_rows[$];
    int     errors = 0;
    int     n_res = 0;
    int     n_items = 0;
    int     snd_idle = 0;
    int     rcv_stall = 0;
    longint wall = 20;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic longint round_q(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic bit in_frame(longint x, longint y);
        return x >= 0 && x <= IMG_W_Q && y >= 0 && y <= IMG_H_Q;
    endfunction

    function automatic longint sat32(longint a, longint b);
        return (a + b > VAR_MAX) ? VAR_MAX : a + b;
    endfunction

    function automatic longint sx(longint v, int w);
        longint m;
        m = longint'(1) << (w - 1);
        v = v & ((longint'(1) << w) - 1);
        return (v ^ m) - m;
    endfunction

    function automatic void push_res(logic [1:0] kind, longint x, longint y,
                                     longint vx, longint vy);
        res_t r;
        r.kind  = kind;
        r.pos_x = x[POS_W-1:0];
        r.pos_y = y[POS_W-1:0];
        r.var_x = vx[VAR_W-1:0];
        r.var_y = vy[VAR_W-1:0];
        r.last  = 1'b0;
        track_q.insert(track_q.size(), r);
    endfunction

    function automatic void drop_track();
        trk = 0;
        prd_x = 0;
        prd_y = 0;
        pvar_x = 0;
        pvar_y = 0;
        evar_x = 0;
        evar_y = 0;
    endfunction

    function automatic void run_predict();
        longint du_y, du_p, tx, ty;
        if (!trk)
            return;
        du_y = ang_rd_y - ang_us_y;
        du_p = ang_rd_p - ang_us_p;
        ang_us_y = ang_rd_y;
        ang_us_p = ang_rd_p;
        tx = est_x + round_q(gn_x * du_y, 256);
        ty = est_y + round_q(gn_y * du_p, 256);
        if (in_frame(tx, ty))
        begin
            est_x = tx;
            est_y = ty;
            prd_x = tx;
            prd_y = ty;
            evar_x = sat32(evar_x, mot_x);
            evar_y = sat32(evar_y, mot_y);
            pvar_x = evar_x;
            pvar_y = evar_y;
            push_res(KIND_PRED, prd_x, prd_y, pvar_x, pvar_y);
        end
        if (prd_x < 256 && prd_y < 256)
            drop_track();
    endfunction

    function automatic void blend(longint prd, longint p, longint r, longint det,
                                  output longint pos, output longint v);
        longint s;
        s = p + r;
        if (s == 0)
        begin
            pos = prd;
            v = 0;
        end
        else
        begin
            pos = prd + round_q(p * (det - prd), s);
            v = round_q(p * r, s);
        end
    endfunction

    // Works out the results of one accepted beat and queues them.
    function automatic void track_step(logic [1:0] cmd, longint dx, longint dy,
                                       longint yaw, longint pitch, longint now);
        int     base;
        longint tx, ty, vx, vy;
        base = track_q.size();
        if (cmd == CMD_DETECT)
        begin
            last_det = now;
            if (!trk)
            begin
                est_x = dx;
                est_y = dy;
                trk = 1;
                run_predict();
            end
            else
            begin
                run_predict();
                blend(prd_x, pvar_x, sens_x, dx, tx, vx);
                blend(prd_y, pvar_y, sens_y, dy, ty, vy);
                if (in_frame(tx, ty))
                begin
                    est_x = tx;
                    est_y = ty;
                    evar_x = vx;
                    evar_y = vy;
                    push_res(KIND_EST, est_x, est_y, evar_x, evar_y);
                end
            end
        end
        else if (cmd == CMD_ANGLE)
        begin
            ang_rd_y = yaw;
            ang_rd_p = pitch;
            run_predict();
        end
        else if (cmd == CMD_FRAME)
        begin
            if (now - last_det > tmo)
            begin
                drop_track();
                push_res(KIND_TIMEOUT, 0, 0, 0, 0);
            end
        end
        if (track_q.size() > base)
            track_q[track_q.size() - 1].last = 1'b1;
    endfunction

    task automatic write_reg(logic [CFGI_W-1:0] idx, longint val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFGV_W-1:0];
        @(posedge clk);
        case (idx)
            REG_SENSOR_VAR_X: sens_x = val;
            REG_SENSOR_VAR_Y: sens_y = val;
            REG_MOTION_VAR_X: mot_x = val;
            REG_MOTION_VAR_Y: mot_y = val;
            REG_GAIN_X:       gn_x = val;
            REG_GAIN_Y:       gn_y = val;
            REG_TIMEOUT:      tmo = val;
            default:          ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (track_q.size() == 0);
        // A detection that yields nothing may still be dividing.
        repeat (300) @(posedge clk);
    endtask

    task automatic load_regs(longint sx_, longint sy_, longint mx, longint my,
                             longint gx, longint gy, longint t);
        drain();
        write_reg(REG_SENSOR_VAR_X, sx_);
        write_reg(REG_SENSOR_VAR_Y, sy_);
        write_reg(REG_MOTION_VAR_X, mx);
        write_reg(REG_MOTION_VAR_Y, my);
        write_reg(REG_GAIN_X, gx);
        write_reg(REG_GAIN_Y, gy);
        write_reg(REG_TIMEOUT, t);
    endtask

    // Leaves tvalid high after the accepting edge; the next call or the caller lowers it.
    task automatic send_beat(logic [1:0] cmd, longint dx, longint dy, longint yaw,
                             longint pitch, longint now, output int base);
        // The model sees the fields exactly as the port carries them.
        dx = sx(dx, POS_W);
        dy = sx(dy, POS_W);
        yaw = sx(yaw, ANG_W);
        pitch = sx(pitch, ANG_W);
        @(negedge clk);
        while ($urandom_range(99) < snd_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {now[31:0], pitch[ANG_W-1:0], yaw[ANG_W-1:0],
                    dy[POS_W-1:0], dx[POS_W-1:0]};
        do
            @(posedge clk);
        while (!s_tready);
        base = track_q.size();
        track_step(cmd, dx, dy, yaw, pitch, now);
        if (cmd != CMD_UNUSED)
            n_items++;
    endtask

    function automatic row_t mk(logic [1:0] cmd, longint dx, longint dy, longint yaw,
                                longint pitch, longint now);
        row_t r;
        r.cmd = cmd;
        r.dx = dx;
        r.dy = dy;
        r.yaw = yaw;
        r.pitch = pitch;
        r.now = now;
        r.typed = 0;
        r.want = '0;
        return r;
    endfunction

    function automatic row_t mk_typed(row_t r, logic [1:0] kind, longint x, longint y,
                                      longint vx, longint vy);
        r.typed = 1;
        r.want = '{kind: kind, pos_x: x[POS_W-1:0], pos_y: y[POS_W-1:0],
                   var_x: vx[VAR_W-1:0], var_y: vy[VAR_W-1:0], last: 1'b1};
        return r;
    endfunction

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= rcv_stall);

    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind  = m_tuser;
            got.pos_x = m_tdata[18:0];
            got.pos_y = m_tdata[37:19];
            got.var_x = m_tdata[69:38];
            got.var_y = m_tdata[101:70];
            got.last  = m_tlast;
            n_res++;
            if (track_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat kind=%0d pos=%0d,%0d var=%0d,%0d",
                         $time, got.kind, got.pos_x, got.pos_y, got.var_x, got.var_y);
            end
            else
            begin
                want = track_q.pop_front();
                if (got.kind !== want.kind)
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
                if (got.pos_x !== want.pos_x)
                    $display("%0t: pos_x expected %0d actual %0d", $time, want.pos_x, got.pos_x);
                if (got.pos_y !== want.pos_y)
                    $display("%0t: pos_y expected %0d actual %0d", $time, want.pos_y, got.pos_y);
                if (got.var_x !== want.var_x)
                    $display("%0t: var_x expected %0d actual %0d", $time, want.var_x, got.var_x);
                if (got.var_y !== want.var_y)
                    $display("%0t: var_y expected %0d actual %0d", $time, want.var_y, got.var_y);
                if (got.last !== want.last)
                    $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
                if (got !== want)
                    errors++;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("pan_tilt_target_kalman_tracker_tb: done, errors");
        $finish;
    end

    initial
    begin
        int     base;
        int     pick;
        longint dx, dy, yaw, pitch;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_DETECT;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_SENSOR_VAR_X;
        cfg_data = '0;
        sens_x = 454853;
        sens_y = 1999032;
        mot_x = 30985;
        mot_y = 30985;
        gn_x = 4096;
        gn_y = 3072;
        tmo = 4;
        trk = 0;
        est_x = 0; est_y = 0;
        ang_rd_y = 0; ang_rd_p = 0; ang_us_y = 0; ang_us_p = 0;
        last_det = 0;
        drop_track();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        dir_rows.insert(dir_rows.size(),
                        mk_typed(mk(CMD_FRAME, 0, 0, 0, 0, 10), KIND_TIMEOUT, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(), mk(CMD_UNUSED, -1, -1, -1, -1, -1));
        dir_rows.insert(dir_rows.size(), mk_typed(mk(CMD_DETECT, 25600, 25600, 0, 0, 10),
                                    KIND_PRED, 25600, 25600, 30985, 30985));
        dir_rows.insert(dir_rows.size(), mk(CMD_ANGLE, 0, 0, 46080, -46080, 0));
        dir_rows.insert(dir_rows.size(), mk(CMD_ANGLE, 0, 0, 100, 50, 0));
        dir_rows.insert(dir_rows.size(), mk(CMD_DETECT, 30000, 20000, 0, 0, 11));
        dir_rows.insert(dir_rows.size(), mk(CMD_DETECT, 262143, -262144, 0, 0, 11));
        dir_rows.insert(dir_rows.size(), mk(CMD_DETECT, 0, 0, 0, 0, 12));
        dir_rows.insert(dir_rows.size(), mk(CMD_FRAME, 0, 0, 0, 0, 12));
        dir_rows.insert(dir_rows.size(), mk(CMD_FRAME, 0, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(), mk(CMD_FRAME, 0, 0, 0, 0, 32'hFFFF_FFFF));
        // A track started at the origin resets on its own prediction.
        dir_rows.insert(dir_rows.size(), mk(CMD_DETECT, 0, 0, 0, 0, 100));
        dir_rows.insert(dir_rows.size(), mk(CMD_DETECT, 0, 0, 0, 0, 100));
        dir_rows.insert(dir_rows.size(), mk(CMD_DETECT, IMG_W_Q, IMG_H_Q, 0, 0, 101));
        dir_rows.insert(dir_rows.size(), mk(CMD_DETECT, IMG_W_Q, IMG_H_Q, 0, 0, 101));
        dir_rows.insert(dir_rows.size(), mk(CMD_ANGLE, 0, 0, -46080, 46080, 0));
        dir_rows.insert(dir_rows.size(),
                        mk(CMD_DETECT, -262144, 262143, 0, 0, 32'hFFFF_FFFF));
        dir_rows.insert(dir_rows.size(), mk(CMD_DETECT, 50000, 40000, 0, 0, 32'hFFFF_FFFF));
        dir_rows.insert(dir_rows.size(), mk(CMD_ANGLE, 0, 0, 0, 0, 0));
        dir_rows.insert(dir_rows.size(), mk(CMD_DETECT, 60000, 50000, 0, 0, 3));
        dir_rows.insert(dir_rows.size(), mk(CMD_FRAME, 0, 0, 0, 0, 9));

        foreach (dir_rows[i])
        begin
            send_beat(dir_rows[i].cmd, dir_rows[i].dx, dir_rows[i].dy,
                      dir_rows[i].yaw, dir_rows[i].pitch, dir_rows[i].now, base);
            if (dir_rows[i].typed)
            begin
                while (track_q.size() > base)
                    void'(track_q.pop_back());
                track_q.insert(track_q.size(), dir_rows[i].want);
            end
        end

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: load_regs(454853, 1999032, 30985, 30985, 4096, 3072, 4);
                1: load_regs(1, 1, 0, 0, 0, 0, 0);
                2: load_regs(16777216, 16777216, 16777216, 16777216, 65535, 65535, 255);
                default: load_regs($urandom_range(16777216, 1), $urandom_range(16777216, 1),
                                   $urandom_range(200000), $urandom_range(200000),
                                   $urandom_range(65535), $urandom_range(65535),
                                   $urandom_range(12));
            endcase
            for (int k = 0; k < 330; k++)
            begin
                int idx;
                idx = ph * 330 + k;
                snd_idle = (idx < 550) ? 27 : (idx < 1100) ? 49 : 0;
                rcv_stall = (idx < 550) ? 49 : (idx < 1100) ? 27 : 0;
                if ($urandom_range(99) < 10)
                begin
                    snd_idle = 0;
                    rcv_stall = 0;
                end
                if (ph == 1 && k == 100)
                begin
                    @(negedge clk);
                    s_tvalid <= 1'b0;
                    wait (track_q.size() == 0);
                end
                pick = $urandom_range(99);
                wall += $urandom_range(2);
                if ($urandom_range(99) < 3)
                    wall += $urandom_range(300);
                if (pick < 45)
                begin
                    if ($urandom_range(1) && trk)
                    begin
                        dx = est_x + $signed($urandom_range(4096)) - 2048;
                        dy = est_y + $signed($urandom_range(4096)) - 2048;
                    end
                    else
                    begin
                        dx = $urandom_range(IMG_W_Q);
                        dy = $urandom_range(IMG_H_Q);
                    end
                    send_beat(CMD_DETECT, dx, dy, 0, 0, wall[31:0], base);
                end
                else if (pick < 75)
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        yaw = $urandom_range(92160) - 46080;
                        pitch = $urandom_range(92160) - 46080;
                    end
                    else
                    begin
                        yaw = ang_rd_y + $urandom_range(1024) - 512;
                        pitch = ang_rd_p + $urandom_range(1024) - 512;
                        yaw = (yaw > 46080) ? 46080 : (yaw < -46080) ? -46080 : yaw;
                        pitch = (pitch > 46080) ? 46080 : (pitch < -46080) ? -46080 : pitch;
                    end
                    send_beat(CMD_ANGLE, sx($urandom, 19), sx($urandom, 19), yaw, pitch,
                              $urandom, base);
                end
                else if (pick < 92)
                    send_beat(CMD_FRAME, sx($urandom, 19), sx($urandom, 19),
                              sx($urandom, 17), sx($urandom, 17), wall[31:0], base);
                else if (pick < 97)
                    send_beat(CMD_DETECT, sx($urandom, 19), sx($urandom, 19),
                              sx($urandom, 17), sx($urandom, 17), $urandom, base);
                else
                    send_beat(CMD_UNUSED, sx($urandom, 19), sx($urandom, 19),
                              sx($urandom, 17), sx($urandom, 17), $urandom, base);
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (track_q.size() == 0);
        repeat (300) @(posedge clk);
        $display("Tracker run: %0d command beats over 5 register settings, %0d result beats.",
                 n_items, n_res);
        $display("Covered first detections, predict/update, bounds rejects and timeouts.");
        if (errors == 0)
            $display("pan_tilt_target_kalman_tracker_tb: done, clean");
        else
            $display("pan_tilt_target_kalman_tracker_tb: done, errors");
        $finish;
    end

endmodule
